// ===== hdl/g2bac_pkg.sv =====
// Shared constants, types and helpers for the gamma-2 bilinear alpha composite unit.
package g2bac_pkg;

  localparam int NUM_CH     = 3;
  localparam int NUM_TEX    = 4;
  localparam int SQRT_STEPS = 8;
  localparam int PIPE_DEPTH = 4 + SQRT_STEPS;

  localparam int BYTE_W  = 8;
  localparam int WGT_W   = 9;
  localparam int SQ_W    = 16;
  localparam int HLIN_W  = 24;
  localparam int LIN_W   = 32;
  localparam int DPROD_W = 40;
  localparam int NUM_W   = 42;
  localparam int ROOT_W  = NUM_W - 16;

  localparam logic [HLIN_W-1:0] ALPHA_FULL = 24'd16711680;
  localparam logic [ROOT_W-1:0] SAT_LEVEL  = 26'd16581375;
  localparam logic [BYTE_W-1:0] BYTE_MAX   = 8'hFF;
  localparam logic [WGT_W-1:0]  WGT_ONE    = 9'd256;

  typedef logic [NUM_CH-1:0][SQ_W-1:0]    sq_vec_t;
  typedef logic [NUM_CH-1:0][HLIN_W-1:0]  hlin_vec_t;
  typedef logic [NUM_CH-1:0][LIN_W-1:0]   lin_vec_t;
  typedef logic [NUM_CH-1:0][DPROD_W-1:0] dprod_vec_t;
  typedef logic [NUM_CH-1:0][ROOT_W-1:0]  root_vec_t;
  typedef logic [NUM_CH-1:0][BYTE_W-1:0]  byte_vec_t;

  // channel 0 = R, 1 = G, 2 = B
  function automatic logic [BYTE_W-1:0] chan_byte(input logic [31:0] px, input logic [1:0] c);
    logic [BYTE_W-1:0] b;
    case (c)
      2'd0: begin
        b = px[23:16];
      end
      2'd1: begin
        b = px[15:8];
      end
      default: begin
        b = px[7:0];
      end
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/gamma2_bilinear_alpha_composite_unit.sv =====
// Gamma-2 bilinear texture filter with premultiplied-alpha composite, pipelined.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   input    | start / busy       | in_texel_* (4 x ARGB), in_frac_x/y, in_dest_pixel
//   result   | out_valid (strobe) | out_blended_pixel
//
// One pixel per clock; busy is always low. Each pixel passes through four arithmetic
// stages (square, horizontal, vertical + dest product, composite), then an 8-stage
// restoring square root, one result bit per stage.
// Reset clears only the valid bits. The result strobe lasts one cycle and cannot be
// held off, so the pipeline never stalls.
module gamma2_bilinear_alpha_composite_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_texel_top_left,
  input  logic [31:0] in_texel_top_right,
  input  logic [31:0] in_texel_bottom_left,
  input  logic [31:0] in_texel_bottom_right,
  input  logic [7:0]  in_frac_x,
  input  logic [7:0]  in_frac_y,
  input  logic [31:0] in_dest_pixel,
  output logic        out_valid,
  output logic [31:0] out_blended_pixel
);
  import g2bac_pkg::*;

  logic                 in_xfer;
  logic [31:0]          tex [NUM_TEX];

  // stage 1: squares, alpha horizontal
  logic                 s1_v_r;
  sq_vec_t              s1_tsq_r [NUM_TEX];
  sq_vec_t              s1_tsq_nxt [NUM_TEX];
  sq_vec_t              s1_dsq_r, s1_dsq_nxt;
  logic [SQ_W-1:0]      s1_atop_r, s1_atop_nxt, s1_abot_r, s1_abot_nxt;
  logic [BYTE_W-1:0]    s1_da_r;
  logic [WGT_W-1:0]     s1_wx0_r, s1_wx1_r, s1_wy0_r, s1_wy1_r;
  logic [WGT_W-1:0]     wx0, wx1, wy0, wy1;

  // stage 2: colour horizontal, alpha vertical
  logic                 s2_v_r;
  hlin_vec_t            s2_ctop_r, s2_ctop_nxt, s2_cbot_r, s2_cbot_nxt;
  logic [HLIN_W-1:0]    s2_ab_r, s2_ab_nxt;
  sq_vec_t              s2_dsq_r;
  logic [BYTE_W-1:0]    s2_da_r;
  logic [WGT_W-1:0]     s2_wy0_r, s2_wy1_r;

  // stage 3: colour vertical, destination products, alpha numerator
  logic                 s3_v_r;
  lin_vec_t             s3_lc_r, s3_lc_nxt;
  dprod_vec_t           s3_invd_r, s3_invd_nxt;
  logic [SQ_W-1:0]      s3_q_r, s3_q_nxt;
  logic [HLIN_W-1:0]    inv;
  logic [LIN_W-1:0]     na;

  // stage 4: composite numerator, alpha quotient estimate
  logic                 s4_v_r;
  root_vec_t            s4_x_r, s4_x_nxt;
  logic [NUM_CH-1:0]    s4_sat_r, s4_sat_nxt;
  logic [SQ_W-1:0]      s4_q_r;
  logic [BYTE_W-1:0]    s4_q0_r, s4_q0_nxt;
  logic [NUM_W-1:0]     nc;
  logic [HLIN_W-1:0]    q257;

  // square root stages
  logic [SQRT_STEPS-1:0] sr_v_r;
  byte_vec_t            sr_k_r [SQRT_STEPS];
  byte_vec_t            sr_k_nxt [SQRT_STEPS];
  root_vec_t            sr_x_r [SQRT_STEPS-1];
  root_vec_t            sr_x_nxt [SQRT_STEPS-1];
  logic [NUM_CH-1:0]    sr_sat_r [SQRT_STEPS-1];
  logic [NUM_CH-1:0]    sr_sat_nxt [SQRT_STEPS-1];
  logic [BYTE_W-1:0]    sr_a_r [SQRT_STEPS];
  logic [BYTE_W-1:0]    sr_a_nxt [SQRT_STEPS];

  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  assign tex[0] = in_texel_top_left;
  assign tex[1] = in_texel_top_right;
  assign tex[2] = in_texel_bottom_left;
  assign tex[3] = in_texel_bottom_right;

  assign wx1 = {1'b0, in_frac_x};
  assign wx0 = WGT_ONE - wx1;
  assign wy1 = {1'b0, in_frac_y};
  assign wy0 = WGT_ONE - wy1;

  always_comb begin
    logic [BYTE_W-1:0] b;
    for (int t = 0; t < NUM_TEX; t++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        b = chan_byte(tex[t], 2'(c));
        s1_tsq_nxt[t][c] = SQ_W'(b) * SQ_W'(b);
      end
    end
    for (int c = 0; c < NUM_CH; c++) begin
      b = chan_byte(in_dest_pixel, 2'(c));
      s1_dsq_nxt[c] = SQ_W'(b) * SQ_W'(b);
    end
    s1_atop_nxt = SQ_W'(in_texel_top_left[31:24]) * SQ_W'(wx0)
                + SQ_W'(in_texel_top_right[31:24]) * SQ_W'(wx1);
    s1_abot_nxt = SQ_W'(in_texel_bottom_left[31:24]) * SQ_W'(wx0)
                + SQ_W'(in_texel_bottom_right[31:24]) * SQ_W'(wx1);
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s2_ctop_nxt[c] = HLIN_W'(s1_tsq_r[0][c]) * HLIN_W'(s1_wx0_r)
                     + HLIN_W'(s1_tsq_r[1][c]) * HLIN_W'(s1_wx1_r);
      s2_cbot_nxt[c] = HLIN_W'(s1_tsq_r[2][c]) * HLIN_W'(s1_wx0_r)
                     + HLIN_W'(s1_tsq_r[3][c]) * HLIN_W'(s1_wx1_r);
    end
    s2_ab_nxt = HLIN_W'(s1_atop_r) * HLIN_W'(s1_wy0_r) + HLIN_W'(s1_abot_r) * HLIN_W'(s1_wy1_r);
  end

  assign inv = ALPHA_FULL - s2_ab_r;
  assign na  = LIN_W'({s2_ab_r, 8'd0}) - LIN_W'(s2_ab_r) + LIN_W'(inv) * LIN_W'(s2_da_r);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s3_lc_nxt[c]   = LIN_W'(s2_ctop_r[c]) * LIN_W'(s2_wy0_r)
                     + LIN_W'(s2_cbot_r[c]) * LIN_W'(s2_wy1_r);
      s3_invd_nxt[c] = DPROD_W'(inv) * DPROD_W'(s2_dsq_r[c]);
    end
    s3_q_nxt = na[31:16];
  end

  // x = floor(nc / 65536); output byte k is the largest with 255*k*k <= x
  always_comb begin
    nc = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      nc = NUM_W'({s3_lc_r[c], 8'd0}) - NUM_W'(s3_lc_r[c]) + NUM_W'(s3_invd_r[c]);
      s4_x_nxt[c]   = nc[NUM_W-1:16];
      s4_sat_nxt[c] = (nc[NUM_W-1:16] >= SAT_LEVEL);
    end
    q257      = HLIN_W'({s3_q_r, 8'd0}) + HLIN_W'(s3_q_r);
    s4_q0_nxt = q257[23:16];
  end

  always_comb begin
    byte_vec_t         src_k;
    root_vec_t         src_x;
    logic [NUM_CH-1:0] src_sat;
    logic [BYTE_W-1:0] tk;
    logic [SQ_W-1:0]   t2;
    logic [HLIN_W-1:0] t255;
    logic [SQ_W-1:0]   rem;
    logic [BYTE_W:0]   a9;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      if (j == 0) begin
        src_k   = '0;
        src_x   = s4_x_r;
        src_sat = s4_sat_r;
      end else begin
        src_k   = sr_k_r[j-1];
        src_x   = sr_x_r[j-1];
        src_sat = sr_sat_r[j-1];
      end
      for (int c = 0; c < NUM_CH; c++) begin
        tk   = src_k[c] | (8'h80 >> j);
        t2   = SQ_W'(tk) * SQ_W'(tk);
        t255 = HLIN_W'({t2, 8'd0}) - HLIN_W'(t2);
        sr_k_nxt[j][c] = (ROOT_W'(t255) <= src_x[c]) ? tk : src_k[c];
        if (j == SQRT_STEPS - 1 && src_sat[c]) begin
          sr_k_nxt[j][c] = BYTE_MAX;
        end
      end
      if (j < SQRT_STEPS - 1) begin
        sr_x_nxt[j]   = src_x;
        sr_sat_nxt[j] = src_sat;
      end
    end
    // alpha quotient correction: q0 is low by at most one
    rem = s4_q_r - SQ_W'(s4_q0_r) * SQ_W'(BYTE_MAX);
    a9  = (rem >= SQ_W'(BYTE_MAX)) ? ({1'b0, s4_q0_r} + 9'd1) : {1'b0, s4_q0_r};
    sr_a_nxt[0] = a9[BYTE_W] ? BYTE_MAX : a9[BYTE_W-1:0];
    for (int j = 1; j < SQRT_STEPS; j++) begin
      sr_a_nxt[j] = sr_a_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      sr_v_r <= '0;
    end else begin
      s1_v_r <= in_xfer;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      sr_v_r <= {sr_v_r[SQRT_STEPS-2:0], s4_v_r};
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < NUM_TEX; t++) begin
      s1_tsq_r[t] <= s1_tsq_nxt[t];
    end
    s1_dsq_r  <= s1_dsq_nxt;
    s1_atop_r <= s1_atop_nxt;
    s1_abot_r <= s1_abot_nxt;
    s1_da_r   <= in_dest_pixel[31:24];
    s1_wx0_r  <= wx0;
    s1_wx1_r  <= wx1;
    s1_wy0_r  <= wy0;
    s1_wy1_r  <= wy1;

    s2_ctop_r <= s2_ctop_nxt;
    s2_cbot_r <= s2_cbot_nxt;
    s2_ab_r   <= s2_ab_nxt;
    s2_dsq_r  <= s1_dsq_r;
    s2_da_r   <= s1_da_r;
    s2_wy0_r  <= s1_wy0_r;
    s2_wy1_r  <= s1_wy1_r;

    s3_lc_r   <= s3_lc_nxt;
    s3_invd_r <= s3_invd_nxt;
    s3_q_r    <= s3_q_nxt;

    s4_x_r    <= s4_x_nxt;
    s4_sat_r  <= s4_sat_nxt;
    s4_q_r    <= s3_q_r;
    s4_q0_r   <= s4_q0_nxt;

    for (int j = 0; j < SQRT_STEPS; j++) begin
      sr_k_r[j] <= sr_k_nxt[j];
      sr_a_r[j] <= sr_a_nxt[j];
    end
    for (int j = 0; j < SQRT_STEPS - 1; j++) begin
      sr_x_r[j]   <= sr_x_nxt[j];
      sr_sat_r[j] <= sr_sat_nxt[j];
    end
  end

  assign out_valid         = sr_v_r[SQRT_STEPS-1];
  assign out_blended_pixel = {sr_a_r[SQRT_STEPS-1], sr_k_r[SQRT_STEPS-1][0],
                              sr_k_r[SQRT_STEPS-1][1], sr_k_r[SQRT_STEPS-1][2]};

  // opaque texels give an opaque result
  a_opaque_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_texel_top_left[31:24] == 8'hFF
                        && in_texel_top_right[31:24] == 8'hFF
                        && in_texel_bottom_left[31:24] == 8'hFF
                        && in_texel_bottom_right[31:24] == 8'hFF, PIPE_DEPTH))
    |-> out_blended_pixel[31:24] == 8'hFF)
    else $error("opaque source did not give opaque alpha");

  // fully transparent black texels pass the destination through
  a_clear_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_texel_top_left == 32'd0 && in_texel_top_right == 32'd0
                        && in_texel_bottom_left == 32'd0
                        && in_texel_bottom_right == 32'd0, PIPE_DEPTH))
    |-> out_blended_pixel == $past(in_dest_pixel, PIPE_DEPTH))
    else $error("clear source did not pass destination");

  // a result strobe always traces back to an accepted transfer
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, PIPE_DEPTH)) |-> $past(start, PIPE_DEPTH))
    else $error("result strobe without transfer");

endmodule
